/* rtl/core/epd_pkg.sv */
// package for the epoch seconds to calendar date block
// types, state codes, calendar and second-count constants, month length function
// no dependencies
package epd_pkg;

	localparam int UnixWidth = 34;
	localparam int ZoneWidth = 17;
	localparam int SumWidth  = 35;
	localparam int SecWidth  = 34;

	localparam logic [ZoneWidth-1:0] ZONE_RESET = 17'd32400;
	localparam logic [11:0] YEAR_BASE     = 12'd1970;
	localparam logic [11:0] YEAR_LAST     = 12'd2242;
	localparam logic [6:0]  YEAR_BASE_100 = 7'd70;
	localparam logic [8:0]  YEAR_BASE_400 = 9'd370;
	localparam logic [6:0]  CENTURY_LAST  = 7'd99;
	localparam logic [8:0]  CYCLE_LAST    = 9'd399;
	localparam logic [3:0]  MONTH_FIRST   = 4'd1;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;

	// seconds in a minute, hour, day, month and year
	localparam logic [SecWidth-1:0] SECS_PER_MINUTE  = 34'd60;
	localparam logic [SecWidth-1:0] SECS_PER_HOUR    = 34'd3600;
	localparam logic [SecWidth-1:0] SECS_PER_DAY     = 34'd86400;
	localparam logic [SecWidth-1:0] SECS_MONTH_28    = 34'd2419200;
	localparam logic [SecWidth-1:0] SECS_MONTH_29    = 34'd2505600;
	localparam logic [SecWidth-1:0] SECS_MONTH_30    = 34'd2592000;
	localparam logic [SecWidth-1:0] SECS_MONTH_31    = 34'd2678400;
	localparam logic [SecWidth-1:0] SECS_COMMON_YEAR = 34'd31536000;
	localparam logic [SecWidth-1:0] SECS_LEAP_YEAR   = 34'd31622400;

	typedef logic signed [ZoneWidth-1:0] zone_t;

	typedef struct packed {
		logic signed [UnixWidth-1:0] unix_seconds;
	} item_t;

	typedef struct packed {
		logic        valid_res;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} result_t;

	typedef struct packed {
		logic    done;
		logic    idle;
		result_t res;
	} seq_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_DAY,
		ST_HOUR,
		ST_MINUTE,
		ST_DONE
	} state_t;

	function automatic logic [SecWidth-1:0] month_seconds(input logic [3:0] m,
			input logic leap);
		logic [SecWidth-1:0] n;
		begin
			unique case (m)
				4'd2:                     n = leap ? SECS_MONTH_29 : SECS_MONTH_28;
				4'd4, 4'd6, 4'd9, 4'd11:  n = SECS_MONTH_30;
				default:                  n = SECS_MONTH_31;
			endcase
			return n;
		end
	endfunction

endpackage

/* rtl/core/epd_stream_if.sv */
// valid/ready channel carrying one payload beat
// payload type is a parameter, no dependencies
interface epd_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/epd_alu.sv */
// shared subtract and compare unit used by every sequencer step
// depends on epd_pkg for widths
module epd_alu (
	input  logic [epd_pkg::SecWidth-1:0] a,
	input  logic [epd_pkg::SecWidth-1:0] b,
	output logic [epd_pkg::SecWidth-1:0] diff,
	output logic                         ge
);
	logic [epd_pkg::SecWidth:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[epd_pkg::SecWidth-1:0];
	assign ge   = ~wide[epd_pkg::SecWidth];
endmodule

/* rtl/core/epd_seq.sv */
// sequencer: year, month, day, hour and minute walk by repeated subtraction
// all steps share one epd_alu; types and constants from epd_pkg
module epd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  epd_pkg::item_t       start_item,
	input  epd_pkg::zone_t       zone,
	input  logic                 take,
	output epd_pkg::seq_status_t status
);
	epd_pkg::state_t state_q, state_nxt;

	logic [epd_pkg::SecWidth-1:0] s_q;
	logic [4:0]  day_q;
	logic [4:0]  hr_q;
	logic [5:0]  min_q;
	logic [11:0] y_q;
	logic [6:0]  c100_q;
	logic [8:0]  c400_q;
	logic [3:0]  m_q;
	logic        ok_q;

	logic signed [epd_pkg::SumWidth-1:0] t_sum;
	logic        leap;
	logic        year_over;
	logic        month_more;
	logic [epd_pkg::SecWidth-1:0] alu_b, alu_diff;
	logic        alu_ge;

	assign t_sum = epd_pkg::SumWidth'(start_item.unix_seconds) + epd_pkg::SumWidth'(zone);
	assign leap = (y_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
	assign year_over = (y_q > epd_pkg::YEAR_LAST);
	assign month_more = (m_q < epd_pkg::MONTH_LAST) && alu_ge;

	epd_alu u_alu (
		.a    (s_q),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			epd_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = t_sum[epd_pkg::SumWidth-1] ? epd_pkg::ST_DONE
						: epd_pkg::ST_YEAR;
				end
			end
			epd_pkg::ST_YEAR: begin
				if (year_over) state_nxt = epd_pkg::ST_DONE;
				else if (!alu_ge) state_nxt = epd_pkg::ST_MONTH;
			end
			epd_pkg::ST_MONTH: begin
				if (!month_more) state_nxt = epd_pkg::ST_DAY;
			end
			epd_pkg::ST_DAY: begin
				if (!alu_ge) state_nxt = epd_pkg::ST_HOUR;
			end
			epd_pkg::ST_HOUR: begin
				if (!alu_ge) state_nxt = epd_pkg::ST_MINUTE;
			end
			epd_pkg::ST_MINUTE: begin
				if (!alu_ge) state_nxt = epd_pkg::ST_DONE;
			end
			epd_pkg::ST_DONE: begin
				if (take) state_nxt = epd_pkg::ST_IDLE;
			end
			default: state_nxt = epd_pkg::ST_IDLE;
		endcase
	end

	// operand select for the shared unit
	always_comb begin
		unique case (state_q)
			epd_pkg::ST_YEAR: begin
				alu_b = leap ? epd_pkg::SECS_LEAP_YEAR : epd_pkg::SECS_COMMON_YEAR;
			end
			epd_pkg::ST_MONTH:  alu_b = epd_pkg::month_seconds(m_q, leap);
			epd_pkg::ST_DAY:    alu_b = epd_pkg::SECS_PER_DAY;
			epd_pkg::ST_HOUR:   alu_b = epd_pkg::SECS_PER_HOUR;
			epd_pkg::ST_MINUTE: alu_b = epd_pkg::SECS_PER_MINUTE;
			default:            alu_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// datapath, remaining seconds in s_q, zero-based day count in day_q
	always_ff @(posedge clk) begin
		unique case (state_q)
			epd_pkg::ST_IDLE: begin
				if (start) begin
					ok_q   <= ~t_sum[epd_pkg::SumWidth-1];
					s_q    <= t_sum[epd_pkg::SecWidth-1:0];
					y_q    <= epd_pkg::YEAR_BASE;
					c100_q <= epd_pkg::YEAR_BASE_100;
					c400_q <= epd_pkg::YEAR_BASE_400;
					m_q    <= epd_pkg::MONTH_FIRST;
					day_q  <= '0;
					hr_q   <= '0;
					min_q  <= '0;
				end
			end
			epd_pkg::ST_YEAR: begin
				if (year_over) begin
					ok_q <= 1'b0;
				end else if (alu_ge) begin
					s_q    <= alu_diff;
					y_q    <= y_q + 12'd1;
					c100_q <= (c100_q == epd_pkg::CENTURY_LAST) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == epd_pkg::CYCLE_LAST) ? 9'd0 : c400_q + 9'd1;
				end
			end
			epd_pkg::ST_MONTH: begin
				if (month_more) begin
					s_q <= alu_diff;
					m_q <= m_q + 4'd1;
				end
			end
			epd_pkg::ST_DAY: begin
				if (alu_ge) begin
					s_q   <= alu_diff;
					day_q <= day_q + 5'd1;
				end
			end
			epd_pkg::ST_HOUR: begin
				if (alu_ge) begin
					s_q  <= alu_diff;
					hr_q <= hr_q + 5'd1;
				end
			end
			epd_pkg::ST_MINUTE: begin
				if (alu_ge) begin
					s_q   <= alu_diff;
					min_q <= min_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.done = (state_q == epd_pkg::ST_DONE);
		status.idle = (state_q == epd_pkg::ST_IDLE);
		status.res  = '0;
		if (ok_q) begin
			status.res.valid_res = 1'b1;
			status.res.year      = y_q;
			status.res.month     = m_q;
			status.res.day       = day_q + 5'd1;
			status.res.hour      = hr_q;
			status.res.minute    = min_q;
			status.res.second    = s_q[5:0];
		end
	end
endmodule

/* rtl/core/epoch_seconds_to_datetime.sv */
// top level: unix seconds plus zone offset to calendar date and time
// depends on epd_pkg, epd_stream_if, epd_seq, epd_alu
//
// channel  dir  payload               beat when
// item     in   unix_seconds (34 s)   item.valid & item.ready
// result   out  result_t fields       result.valid & result.ready
// cfg      in   zone_offset (17 s)    cfg.valid & cfg.ready
//
// one item: accept, then the year step subtracts whole years, the month step whole
// months up to December, then day, hour and minute by subtraction, then done; all
// steps run one after another on the single shared subtract/compare unit
// a negative shifted time goes straight to done; arst_n clears the sequencer,
// output valid and resets the offset to 32400
// item.ready is high only while idle; done waits for a free output register
module epoch_seconds_to_datetime (
	input  logic       clk,
	input  logic       arst_n,
	epd_stream_if.sink   item,
	epd_stream_if.source result,
	epd_stream_if.sink   cfg
);
	epd_pkg::zone_t       zone_q;
	epd_pkg::seq_status_t status;
	epd_pkg::result_t     res_q;
	logic                 res_valid_q;
	logic                 take;

	assign cfg.ready  = 1'b1;
	assign item.ready = status.idle;
	assign take       = status.done && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= epd_pkg::ZONE_RESET;
		end else if (cfg.valid) begin
			zone_q <= cfg.data;
		end
	end

	epd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (item.valid && item.ready),
		.start_item (item.data),
		.zone       (zone_q),
		.take       (take),
		.status     (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= status.res;
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;
endmodule

/* rtl/core/epd_checker.sv */
// port-level checks for epoch_seconds_to_datetime, attached by bind
// depends on epd_pkg for the result type
module epd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             res_valid,
	input logic             res_ready,
	input epd_pkg::result_t res
);
	// result beat holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat dropped or changed while stalled");

	// block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while conversion running");

	// invalid result carries all-zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.valid_res |-> res.year == 12'd0 && res.month == 4'd0
			&& res.day == 5'd0 && res.hour == 5'd0 && res.minute == 6'd0
			&& res.second == 6'd0)
		else $error("invalid result with nonzero fields");

	// valid result lies on the calendar
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.valid_res |-> res.year >= 12'd1970 && res.year <= 12'd2242
			&& res.month >= 4'd1 && res.month <= 4'd12 && res.day >= 5'd1
			&& res.hour < 5'd24 && res.minute < 6'd60 && res.second < 6'd60)
		else $error("result outside calendar range");
endmodule

bind epoch_seconds_to_datetime epd_checker u_epd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res        (result.data)
);
